FILE: sv/ggvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggvc_pkg
// Shared types, widths and constants of the go-to-goal velocity controller.
// ----------------------------------------------------------------------------
package ggvc_pkg;

  // field and datapath widths
  localparam int QW       = 16;   // quaternion component, Q1.14
  localparam int POS_W    = 32;   // world position, Q16.16
  localparam int OFS_W    = 33;   // world offset, exact
  localparam int MAT_W    = 27;   // rotation block entry, Q20
  localparam int DET_W    = 55;   // determinant, Q40
  localparam int ADET_W   = 54;   // determinant magnitude
  localparam int U_W      = 62;   // robot-frame offset times det, Q36
  localparam int ZW       = 34;   // heading, Q2.30
  localparam int MAG_W    = 62;   // scaled magnitude
  localparam int DIV_FRAC = 20;
  localparam int DIV_BITS = MAG_W + DIV_FRAC;
  localparam int DIST_W   = 41;   // distance, capped at 2^40
  localparam int GAIN_W   = 16;
  localparam int REG_W    = 31;
  localparam int MA_W     = 32;   // shared multiplier operand a
  localparam int MB_W     = 34;   // shared multiplier operand b
  localparam int MP_W     = MA_W + MB_W;

  localparam logic [29:0]       INV_GAIN = 30'd652032874;
  localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;
  localparam logic [DIST_W-1:0] DIST_CAP = {1'b1, {(DIST_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LINEAR_GAIN  = 2'd0,
    REG_ANGULAR_GAIN = 2'd1,
    REG_STOP_RADIUS  = 2'd2,
    REG_HEADING_TOL  = 2'd3
  } reg_idx_t;

  // sequencer states
  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_QUAT   = 11'b000_0000_0010,
    S_MATRIX = 11'b000_0000_0100,
    S_ADJ    = 11'b000_0000_1000,
    S_PREROT = 11'b000_0001_0000,
    S_CORDIC = 11'b000_0010_0000,
    S_SCALE  = 11'b000_0100_0000,
    S_DIVIDE = 11'b000_1000_0000,
    S_CMD    = 11'b001_0000_0000,
    S_REACH  = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_t;

  // arctangent of 2^-i, Q2.30, truncated
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/go_to_goal_velocity_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller_core
// Proportional go-to-goal controller run on one shared multiplier.
// ----------------------------------------------------------------------------
// Each input word is one control tick: robot pose and, with load_target set,
// a new goal that arms the block. Exactly one output word leaves per tick.
// in_stall is high while a tick is being worked on; a word is taken when
// in_valid is high and in_stall low. The result sits in an output register
// until out_valid is high with out_stall low; a new tick may be taken while
// it waits, and that tick holds in its last state until the register frees.
// An unarmed tick goes straight to the output load. An armed tick runs the
// matrix and adjugate products, a pre-rotation step, CORDIC_STEPS (at most
// 32) vectoring steps, gain scaling, the bit-serial divider, then the
// commands, the reach test and the output load. A zero determinant skips
// CORDIC, gain scaling, the divider and the commands; a zero offset skips
// CORDIC only.
// Configuration writes are always ready and take effect the next cycle.
// Reset (rst_n low, synchronous) disarms, clears the goal and loads the
// register defaults.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_core import ggvc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_load_target,
  input  logic signed [POS_W-1:0] in_target_x,
  input  logic signed [POS_W-1:0] in_target_y,
  input  logic signed [POS_W-1:0] in_robot_x,
  input  logic signed [POS_W-1:0] in_robot_y,
  input  logic signed [QW-1:0]    in_quat_w,
  input  logic signed [QW-1:0]    in_quat_x,
  input  logic signed [QW-1:0]    in_quat_y,
  input  logic signed [QW-1:0]    in_quat_z,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_command_valid,
  output logic signed [POS_W-1:0] out_linear_velocity,
  output logic signed [POS_W-1:0] out_angular_velocity,
  output logic                    out_target_reached,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data
);

  localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  // configuration registers
  logic [GAIN_W-1:0] lin_gain_r, ang_gain_r;
  logic [REG_W-1:0]  stop_r, tol_r;

  // controller state
  logic                    armed_r;
  logic signed [POS_W-1:0] goal_x_r, goal_y_r;

  // tick working registers
  logic signed [QW-1:0]     qw_r, qx_r, qy_r, qz_r;
  logic signed [OFS_W-1:0]  dx_r, dy_r;
  logic signed [31:0]       yy_r, zz_r, xx_r, xy_r, zw_r;
  logic signed [MAT_W-1:0]  a_r, b_r, c_r, d_r;
  logic signed [DET_W-1:0]  det_r;
  logic [ADET_W-1:0]        adet_r;
  logic signed [U_W-1:0]    u0_r, u1_r;
  logic signed [U_W-1:0]    x_r, y_r;
  logic signed [ZW-1:0]     z_r;
  logic [MAG_W-1:0]         mag_r;
  logic [DIST_W-1:0]        dist_r;
  logic [56:0]              lacc_r;
  logic signed [POS_W-1:0]  lin_r, ang_r;
  logic                     cmdv_r, reached_r;

  // output register
  logic                    out_valid_r, out_cmdv_r, out_reached_r;
  logic signed [POS_W-1:0] out_lin_r, out_ang_r;

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] p_r;

  logic in_take, out_free;
  assign in_take  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // configuration port
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_gain_r <= 16'd410;
      ang_gain_r <= 16'd4506;
      stop_r     <= 31'd85197;
      tol_r      <= 31'd131;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_LINEAR_GAIN:  lin_gain_r <= cfg_data[GAIN_W-1:0];
        REG_ANGULAR_GAIN: ang_gain_r <= cfg_data[GAIN_W-1:0];
        REG_STOP_RADIUS:  stop_r     <= cfg_data[REG_W-1:0];
        REG_HEADING_TOL:  tol_r      <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_QUAT: begin
        case (cnt_r)
          5'd0:    begin mul_a = MA_W'(qy_r); mul_b = MB_W'(qy_r); end
          5'd1:    begin mul_a = MA_W'(qz_r); mul_b = MB_W'(qz_r); end
          5'd2:    begin mul_a = MA_W'(qx_r); mul_b = MB_W'(qx_r); end
          5'd3:    begin mul_a = MA_W'(qx_r); mul_b = MB_W'(qy_r); end
          default: begin mul_a = MA_W'(qz_r); mul_b = MB_W'(qw_r); end
        endcase
      end
      S_ADJ: begin
        case (cnt_r)
          5'd0:    begin mul_a = MA_W'(a_r); mul_b = MB_W'(d_r);  end
          5'd1:    begin mul_a = MA_W'(b_r); mul_b = MB_W'(c_r);  end
          5'd2:    begin mul_a = MA_W'(d_r); mul_b = MB_W'(dx_r); end
          5'd3:    begin mul_a = MA_W'(b_r); mul_b = MB_W'(dy_r); end
          5'd4:    begin mul_a = MA_W'(a_r); mul_b = MB_W'(dy_r); end
          default: begin mul_a = MA_W'(c_r); mul_b = MB_W'(dx_r); end
        endcase
      end
      S_SCALE: begin
        mul_b = MB_W'(INV_GAIN);
        if (cnt_r == 5'd0) mul_a = x_r[61:30];
        else               mul_a = {2'b00, x_r[29:0]};
      end
      S_CMD: begin
        case (cnt_r)
          5'd0:    begin mul_a = MA_W'(lin_gain_r); mul_b = MB_W'(dist_r[23:0]);  end
          5'd1:    begin mul_a = MA_W'(lin_gain_r); mul_b = MB_W'(dist_r[40:24]); end
          default: begin mul_a = MA_W'(ang_gain_r); mul_b = z_r;                  end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
  end

  // rotation block entries, rounded to Q20
  logic signed [35:0] ta, tb, tc, td;
  always_comb begin
    ta = 36'sd268435584 - ((36'(yy_r) + 36'(zz_r)) <<< 1);
    td = 36'sd268435584 - ((36'(xx_r) + 36'(zz_r)) <<< 1);
    tb = ((36'(xy_r) - 36'(zw_r)) <<< 1) + 36'sd128;
    tc = ((36'(xy_r) + 36'(zw_r)) <<< 1) + 36'sd128;
  end

  // sign fold ahead of the quadrant pre-rotation
  logic                  det_neg;
  logic signed [U_W-1:0] ux, uy;
  always_comb begin
    det_neg = det_r[DET_W-1];
    ux = det_neg ? -u0_r : u0_r;
    uy = det_neg ? -u1_r : u1_r;
  end

  // vectoring step
  logic signed [U_W-1:0] xs, ys;
  logic signed [ZW-1:0]  at;
  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    at = ZW'(atan_q30(cnt_r));
  end

  // divider
  logic              div_start, div_done;
  logic [MAG_W-1:0]  mag_sum;
  logic [DIST_W-1:0] div_quo;
  assign mag_sum   = mag_r + MAG_W'(p_r >>> 30);
  assign div_start = (state_r == S_SCALE) && (cnt_r == 5'd2);

  ggvc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag_sum),
    .den   (adet_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // command arithmetic
  logic [57:0]        lsum;
  logic [45:0]        lu;
  logic signed [57:0] asum;
  logic [31:0]        aabs;
  always_comb begin
    lsum = 58'(lacc_r) + (58'(p_r[32:0]) << 24) + 58'd2048;
    lu   = lsum[57:12];
    asum = 58'(p_r) + 58'sd33554432;
    aabs = ang_r[31] ? 32'(-ang_r) : 32'(ang_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_take) state_nxt = (in_load_target || armed_r) ? S_QUAT : S_OUT;
      end
      S_QUAT:   if (cnt_r == 5'd5) state_nxt = S_MATRIX;
      S_MATRIX: begin
        cnt_nxt   = '0;
        state_nxt = S_ADJ;
      end
      S_ADJ: begin
        if (cnt_r == 5'd6) begin
          state_nxt = S_PREROT;
          cnt_nxt   = '0;
        end
      end
      S_PREROT: begin
        cnt_nxt = '0;
        if (det_r == '0)               state_nxt = S_REACH;
        else if (ux == '0 && uy == '0) state_nxt = S_SCALE;
        else                           state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        if (cnt_r == 5'(NSTEP - 1)) begin
          state_nxt = S_SCALE;
          cnt_nxt   = '0;
        end
      end
      S_SCALE:  if (cnt_r == 5'd2) state_nxt = S_DIVIDE;
      S_DIVIDE: begin
        cnt_nxt = '0;
        if (div_done) state_nxt = S_CMD;
      end
      S_CMD:    if (cnt_r == 5'd3) state_nxt = S_REACH;
      S_REACH:  state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // goal and arming
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      goal_x_r <= '0;
      goal_y_r <= '0;
    end else if (in_take && in_load_target) begin
      armed_r  <= 1'b1;
      goal_x_r <= in_target_x;
      goal_y_r <= in_target_y;
    end else if (state_r == S_OUT && out_free && reached_r) begin
      armed_r <= 1'b0;
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        qw_r <= in_quat_w;
        qx_r <= in_quat_x;
        qy_r <= in_quat_y;
        qz_r <= in_quat_z;
        dx_r <= OFS_W'(in_load_target ? in_target_x : goal_x_r) - OFS_W'(in_robot_x);
        dy_r <= OFS_W'(in_load_target ? in_target_y : goal_y_r) - OFS_W'(in_robot_y);
        cmdv_r    <= in_load_target || armed_r;
        lin_r     <= '0;
        ang_r     <= '0;
        reached_r <= 1'b0;
      end
      S_QUAT: begin
        case (cnt_r)
          5'd1:    yy_r <= p_r[31:0];
          5'd2:    zz_r <= p_r[31:0];
          5'd3:    xx_r <= p_r[31:0];
          5'd4:    xy_r <= p_r[31:0];
          5'd5:    zw_r <= p_r[31:0];
          default: ;
        endcase
      end
      S_MATRIX: begin
        a_r <= ta[34:8];
        b_r <= tb[34:8];
        c_r <= tc[34:8];
        d_r <= td[34:8];
      end
      S_ADJ: begin
        case (cnt_r)
          5'd1:    det_r <= p_r[DET_W-1:0];
          5'd2:    det_r <= det_r - p_r[DET_W-1:0];
          5'd3:    u0_r  <= p_r[U_W-1:0];
          5'd4:    u0_r  <= u0_r - p_r[U_W-1:0];
          5'd5:    u1_r  <= p_r[U_W-1:0];
          5'd6:    u1_r  <= u1_r - p_r[U_W-1:0];
          default: ;
        endcase
      end
      S_PREROT: begin
        adet_r <= det_neg ? ADET_W'(-det_r) : ADET_W'(det_r);
        if (ux < 0) begin
          if (uy >= 0) begin
            x_r <= uy;
            y_r <= -ux;
            z_r <= HALF_PI;
          end else begin
            x_r <= -uy;
            y_r <= ux;
            z_r <= -HALF_PI;
          end
        end else begin
          x_r <= ux;
          y_r <= uy;
          z_r <= '0;
        end
      end
      S_CORDIC: begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end
      end
      S_SCALE: begin
        if (cnt_r == 5'd1) mag_r <= MAG_W'(p_r);
      end
      S_DIVIDE: begin
        if (div_done) dist_r <= (div_quo <= DIST_W'(stop_r)) ? '0 : div_quo;
      end
      S_CMD: begin
        case (cnt_r)
          5'd1: lacc_r <= p_r[56:0];
          5'd2: lin_r  <= (lu > 46'h7FFF_FFFF) ? 32'sh7FFF_FFFF : lu[31:0];
          5'd3: ang_r  <= asum[57:26];
          default: ;
        endcase
      end
      S_REACH: begin
        reached_r <= (lin_r == '0) && (aabs < {1'b0, tol_r});
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_cmdv_r    <= cmdv_r;
      out_lin_r     <= lin_r;
      out_ang_r     <= ang_r;
      out_reached_r <= reached_r;
    end
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_command_valid    = out_cmdv_r;
  assign out_linear_velocity  = out_lin_r;
  assign out_angular_velocity = out_ang_r;
  assign out_target_reached   = out_reached_r;

endmodule

FILE: sv/ggvc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggvc_divider
// Restoring divider, one quotient bit a cycle: (num * 2^20) / den, capped.
// ----------------------------------------------------------------------------
module ggvc_divider import ggvc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MAG_W-1:0]  num,
  input  logic [ADET_W-1:0] den,
  output logic              done,
  output logic [DIST_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_BITS);

  logic                busy_r, done_r, ovf_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DIV_BITS-1:0] sh_r;
  logic [ADET_W-1:0]   rem_r, den_r;
  logic [DIST_W-1:0]   q_r;
  logic [ADET_W:0]     rsh, rdif;
  logic                ge;

  // one restoring step
  always_comb begin
    rsh  = {rem_r, sh_r[DIV_BITS-1]};
    ge   = rsh >= {1'b0, den_r};
    rdif = rsh - {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= {num, {DIV_FRAC{1'b0}}};
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[DIV_BITS-2:0], 1'b0};
      rem_r <= ge ? rdif[ADET_W-1:0] : rsh[ADET_W-1:0];
      q_r   <= {q_r[DIST_W-2:0], ge};
      ovf_r <= ovf_r | q_r[DIST_W-1];
    end
  end

  assign done = done_r;
  assign quo  = (ovf_r || q_r[DIST_W-1]) ? DIST_CAP : q_r;

endmodule

FILE: bench/go_to_goal_velocity_controller_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller_core_checker
// Watches the tick, command and register channels of the go-to-goal
// controller, predicts each command word from its own copy of the goal, arm
// flag and registers, and compares every accepted command word in order.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_core_checker import ggvc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_load_target,
  input  logic signed [POS_W-1:0] in_target_x,
  input  logic signed [POS_W-1:0] in_target_y,
  input  logic signed [POS_W-1:0] in_robot_x,
  input  logic signed [POS_W-1:0] in_robot_y,
  input  logic signed [QW-1:0]    in_quat_w,
  input  logic signed [QW-1:0]    in_quat_x,
  input  logic signed [QW-1:0]    in_quat_y,
  input  logic signed [QW-1:0]    in_quat_z,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_command_valid,
  input  logic signed [POS_W-1:0] out_linear_velocity,
  input  logic signed [POS_W-1:0] out_angular_velocity,
  input  logic                    out_target_reached,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  output int                      errors,
  output int                      pending,
  output int                      checked,
  output int                      reached_cnt
);

  typedef struct {
    logic              cmd_valid;
    logic signed [31:0] lin;
    logic signed [31:0] ang;
    logic              reached;
  } command_t;

  localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;
  localparam longint          HALF_PI_Q30  = 64'sd1686629713;
  localparam longint unsigned CAP          = 64'd1 << 40;
  localparam int              STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int              RING  = 16;

  localparam longint ATAN_TAB [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0};

  // shadow of the block state and registers
  longint unsigned lin_gain, ang_gain, stop_rad, head_tol;
  logic            goal_armed;
  longint          goal_xs, goal_ys;

  // expected command words, oldest at rd_cnt
  command_t        exp_ring [RING];
  int              wr_cnt, rd_cnt;

  // vectoring rotation: heading in Q2.30 and gain-scaled magnitude
  function automatic longint vector_heading(input longint x0, input longint y0,
                                            output longint unsigned mag);
    longint x, y, z, t, xs, ys;
    x = x0;
    y = y0;
    z = 0;
    mag = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q30;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    mag = longint'(unsigned'(x));
    return z;
  endfunction

  // distance = num * 2^20 / den, truncated and capped
  function automatic longint unsigned distance_div(input longint unsigned num,
                                                   input longint unsigned den);
    longint unsigned r, q, b;
    r = 0;
    q = 0;
    for (int i = 83; i >= 0; i--) begin
      b = (i >= 20) ? ((num >> (i - 20)) & 64'd1) : 64'd0;
      r = (r << 1) | b;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 64'd1;
      end
      if (q >= CAP) return CAP;
    end
    return q;
  endfunction

  // one control tick: updates the shadow state and returns the command
  function automatic command_t predict_command(input logic ld,
      input longint tx, input longint ty, input longint rx, input longint ry,
      input longint qw, input longint qx, input longint qy, input longint qz);
    command_t c;
    longint a, b, cc, d, det, dx, dy, u0, u1, theta, lin, ang, aabs;
    longint unsigned adet, xm, mag, dist_q, lu;
    c = '{1'b0, 32'sd0, 32'sd0, 1'b0};
    if (ld) begin
      goal_xs = tx;
      goal_ys = ty;
      goal_armed = 1'b1;
    end
    if (!goal_armed) return c;
    a  = (64'sd268435456 - 2 * (qy * qy + qz * qz) + 128) >>> 8;
    b  = (2 * (qx * qy - qz * qw) + 128) >>> 8;
    cc = (2 * (qx * qy + qz * qw) + 128) >>> 8;
    d  = (64'sd268435456 - 2 * (qx * qx + qz * qz) + 128) >>> 8;
    det = a * d - b * cc;
    lin = 0;
    ang = 0;
    if (det != 0) begin
      dx = goal_xs - rx;
      dy = goal_ys - ry;
      u0 = d * dx - b * dy;
      u1 = a * dy - cc * dx;
      if (det < 0) begin
        u0 = -u0; u1 = -u1; adet = longint'(unsigned'(-det));
      end else begin
        adet = longint'(unsigned'(det));
      end
      theta = vector_heading(u0, u1, xm);
      mag = (xm >> 30) * INV_GAIN_Q30 + (((xm & 64'h3FFF_FFFF) * INV_GAIN_Q30) >> 30);
      dist_q = distance_div(mag, adet);
      if (dist_q <= stop_rad) dist_q = 0;
      lu = (lin_gain * dist_q + 64'd2048) >> 12;
      lin = (lu > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(lu);
      ang = (longint'(ang_gain) * theta + (64'sd1 <<< 25)) >>> 26;
      if (ang > 64'sh7FFF_FFFF) ang = 64'sh7FFF_FFFF;
      if (ang < -64'sh8000_0000) ang = -64'sh8000_0000;
    end
    aabs = (ang < 0) ? -ang : ang;
    c.cmd_valid = 1'b1;
    c.lin = lin[31:0];
    c.ang = ang[31:0];
    c.reached = (lin == 0) && (longint'(unsigned'(aabs)) < head_tol);
    if (c.reached) goal_armed = 1'b0;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint exp_v);
    errors++;
    $display("mismatch at %0t: %s got %0d, want %0d (word %0d)",
             $realtime, what, got, exp_v, checked);
  endtask

  initial begin
    errors = 0;
    checked = 0;
    reached_cnt = 0;
    wr_cnt = 0;
    rd_cnt = 0;
  end

  assign pending = wr_cnt - rd_cnt;

  // register writes, ticks and command words, in that order per edge
  always @(posedge clk) begin
    command_t e;
    command_t nw;
    if (!rst_n) begin
      lin_gain = 410;
      ang_gain = 4506;
      stop_rad = 85197;
      head_tol = 131;
      goal_armed = 1'b0;
      goal_xs = 0;
      goal_ys = 0;
      wr_cnt = 0;
      rd_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_LINEAR_GAIN:  lin_gain = cfg_data[15:0];
          REG_ANGULAR_GAIN: ang_gain = cfg_data[15:0];
          REG_STOP_RADIUS:  stop_rad = cfg_data[30:0];
          REG_HEADING_TOL:  head_tol = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        nw = predict_command(in_load_target, in_target_x, in_target_y,
            in_robot_x, in_robot_y, in_quat_w, in_quat_x, in_quat_y, in_quat_z);
        if (wr_cnt - rd_cnt >= RING) begin
          errors++;
          $display("mismatch at %0t: too many tick words outstanding", $realtime);
        end else begin
          exp_ring[wr_cnt % RING] = nw;
          wr_cnt++;
        end
      end
      if (out_valid && !out_stall) begin
        if (wr_cnt == rd_cnt) begin
          errors++;
          $display("mismatch at %0t: command word with none expected", $realtime);
        end else begin
          e = exp_ring[rd_cnt % RING];
          rd_cnt++;
          if (out_command_valid !== e.cmd_valid)
            report_mismatch("command_valid", out_command_valid, e.cmd_valid);
          if (out_linear_velocity !== e.lin)
            report_mismatch("linear_velocity", out_linear_velocity, e.lin);
          if (out_angular_velocity !== e.ang)
            report_mismatch("angular_velocity", out_angular_velocity, e.ang);
          if (out_target_reached !== e.reached)
            report_mismatch("target_reached", out_target_reached, e.reached);
          if (e.reached) reached_cnt++;
          checked++;
        end
      end
    end
  end

endmodule

FILE: bench/go_to_goal_velocity_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller_core_tb
// Drives control ticks and register writes into the go-to-goal controller:
// a directed set of corner poses, then goal-seeking runs with random poses
// under several register settings and idle/stall patterns. The checker
// beside the block predicts and compares every command word.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_controller_core_tb import ggvc_pkg::*;;

  localparam int LIMIT = 2000000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_load_target;
  logic signed [POS_W-1:0] in_target_x, in_target_y, in_robot_x, in_robot_y;
  logic signed [QW-1:0]    in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_command_valid;
  logic signed [POS_W-1:0] out_linear_velocity, out_angular_velocity;
  logic                    out_target_reached;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [1:0]              cfg_index;
  logic [31:0]             cfg_data;

  int errors, pending, checked, reached_cnt;
  int idle_pct, stall_pct, hold_req;
  int ticks, loads, cycles;
  logic signed [31:0] goal_x, goal_y;

  go_to_goal_velocity_controller_core i_dut (.*);

  go_to_goal_velocity_controller_core_checker i_chk (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // cycle limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** go_to_goal_velocity_controller_core: FAILED **");
      $finish;
    end
  end

  // receiver: random stall, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      out_stall = 1'b1;
      hold_req--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // block idle: nothing expected, then a wait that outlasts an armed tick
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  // offer one tick word and wait for it to be taken
  task automatic send_tick(input logic ld, input logic signed [31:0] tx,
      input logic signed [31:0] ty, input logic signed [31:0] rx,
      input logic signed [31:0] ry, input logic signed [15:0] qw,
      input logic signed [15:0] qx, input logic signed [15:0] qy,
      input logic signed [15:0] qz);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_load_target = ld;
    in_target_x    = tx;
    in_target_y    = ty;
    in_robot_x     = rx;
    in_robot_y     = ry;
    in_quat_w      = qw;
    in_quat_x      = qx;
    in_quat_y      = qy;
    in_quat_z      = qz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks++;
    if (ld) begin
      loads++;
      goal_x = tx;
      goal_y = ty;
    end
  endtask

  // goal-seeking tick: mostly near the goal, mostly yaw-only orientation
  task automatic random_tick;
    logic ld;
    logic signed [31:0] tx, ty, rx, ry, ox, oy;
    logic signed [15:0] qw, qx, qy, qz;
    int sh;
    ld = ($urandom_range(99) < 12);
    tx = $urandom();
    ty = $urandom();
    if ($urandom_range(3) != 0) begin
      tx = tx >>> $urandom_range(31, 8);
      ty = ty >>> $urandom_range(31, 8);
    end
    sh = $urandom_range(31);
    ox = $signed($urandom()) >>> sh;
    oy = $signed($urandom()) >>> sh;
    if ($urandom_range(9) == 0) begin
      rx = $urandom();
      ry = $urandom();
    end else begin
      rx = (ld ? tx : goal_x) - ox;
      ry = (ld ? ty : goal_y) - oy;
    end
    case ($urandom_range(5))
      0: begin
        qw = $urandom(); qx = $urandom(); qy = $urandom(); qz = $urandom();
      end
      1: begin
        qw = 0; qx = 0; qy = 16'sd8192; qz = 0;
      end
      default: begin
        qw = $signed(16'($urandom_range(32767))) - 16'sd16384;
        qz = $signed(16'($urandom_range(32767))) - 16'sd16384;
        qx = $signed(16'($urandom_range(255))) - 16'sd128;
        qy = $signed(16'($urandom_range(255))) - 16'sd128;
      end
    endcase
    send_tick(ld, tx, ty, rx, ry, qw, qx, qy, qz);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_load_target = 1'b0;
    {in_target_x, in_target_y, in_robot_x, in_robot_y} = '0;
    {in_quat_w, in_quat_x, in_quat_y, in_quat_z} = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LINEAR_GAIN;
    cfg_data = '0;
    out_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    ticks = 0;
    loads = 0;
    goal_x = 0;
    goal_y = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners at reset settings
    send_tick(1'b0, 32'sd100, 32'sd100, 0, 0, 16'sd16384, 0, 0, 0);
    send_tick(1'b1, 32'sd655360, 0, 0, 0, 16'sd16384, 0, 0, 0);
    send_tick(1'b0, 0, 0, 32'sd655360, 0, 16'sd16384, 0, 0, 0);
    send_tick(1'b1, -32'sd655360, 0, 0, 0, 16'sd16384, 0, 0, 0);
    send_tick(1'b1, 0, 32'sd655360, 0, 0, 0, 0, 0, 16'sd16384);
    send_tick(1'b1, 32'sd1000, 32'sd1000, 32'sd1000, 32'sd1000, 16'sd16384, 0, 0, 0);
    send_tick(1'b1, 32'sd655360, 32'sd65536, 0, 0, 0, 0, 16'sd8192, 0);
    send_tick(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_tick(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_tick(1'b1, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
    send_tick(1'b0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh8000, 0, 0, 16'sh7FFF);
    send_tick(1'b1, 32'sd70000, -32'sd70000, 0, 0, 16'sd11585, 0, 0, 16'sd11585);
    send_tick(1'b1, -32'sd65536, -32'sd1, 0, 0, 16'sd16384, 0, 0, 0);
    send_tick(1'b1, 32'sd5, 32'sd7, 0, 0, 16'sd16384, 16'sd300, -16'sd300, 0);
    send_tick(1'b0, 0, 0, 32'sd5, 32'sd7, 16'sd16384, 0, 0, 0);
    send_tick(1'b0, 0, 0, 0, 0, 16'sd16384, 0, 0, 0);

    // register settings, each with an idle and stall pattern
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          write_reg(REG_LINEAR_GAIN, 32'hFFFF);
          write_reg(REG_ANGULAR_GAIN, 32'hFFFF);
          write_reg(REG_STOP_RADIUS, 32'h0);
          write_reg(REG_HEADING_TOL, 32'h0);
          idle_pct = 54; stall_pct = 0;
        end
        2: begin
          write_reg(REG_LINEAR_GAIN, 32'h0);
          write_reg(REG_ANGULAR_GAIN, 32'h0);
          write_reg(REG_STOP_RADIUS, 32'h7FFF_FFFF);
          write_reg(REG_HEADING_TOL, 32'h7FFF_FFFF);
          idle_pct = 0; stall_pct = 54;
        end
        3: begin
          write_reg(REG_LINEAR_GAIN, $urandom_range(65535));
          write_reg(REG_ANGULAR_GAIN, $urandom_range(65535));
          write_reg(REG_STOP_RADIUS, $urandom_range(2000000));
          write_reg(REG_HEADING_TOL, $urandom_range(300000));
          idle_pct = 27; stall_pct = 27;
        end
        default: begin
          write_reg(REG_LINEAR_GAIN, 32'd410);
          write_reg(REG_ANGULAR_GAIN, 32'd4506);
          write_reg(REG_STOP_RADIUS, 32'd85197);
          write_reg(REG_HEADING_TOL, 32'd131);
          idle_pct = 0; stall_pct = 0;
        end
      endcase
      for (int n = 0; n < 168; n++) begin
        if (p == 4 && n == 40) hold_req = 600;
        random_tick();
      end
    end

    drain();
    $display("ran %0d ticks (%0d goal loads), checked %0d command words, %0d reached",
             ticks, loads, checked, reached_cnt);
    $display("five register settings incl. gain/radius extremes, idle and stall mixes");
    if (errors == 0) begin
      $display("** go_to_goal_velocity_controller_core: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** go_to_goal_velocity_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ggvc_pkg.sv
sv/ggvc_divider.sv
sv/go_to_goal_velocity_controller_core.sv
bench/go_to_goal_velocity_controller_core_checker.sv
bench/go_to_goal_velocity_controller_core_tb.sv
